FILE: hdl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define SLS_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define SLS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/sls_pkg.sv
// shared types, constants and keyword table of the token scanner
`default_nettype none

package sls_pkg;

   localparam int POS_WIDTH    = 16;
   localparam int KW_MAX_LEN   = 6;
   localparam int KIND_WIDTH   = 6;
   localparam int PREFIX_WIDTH = 8 * KW_MAX_LEN;
   localparam int RESULTS_MAX  = 3;
   localparam int KW_COUNT     = 14;

   typedef logic [POS_WIDTH-1:0]    pos_type;
   typedef logic [KIND_WIDTH-1:0]   kind_type;
   typedef logic [PREFIX_WIDTH-1:0] prefix_type;

   localparam pos_type POS_MAX = '1;

   localparam kind_type K_OP_BASE  = 6'd10;
   localparam kind_type K_SLASH    = 6'd18;
   localparam kind_type K_STRING   = 6'd19;
   localparam kind_type K_NUMBER   = 6'd20;
   localparam kind_type K_IDENT    = 6'd21;
   localparam kind_type K_KEYWORD0 = 6'd22;
   localparam kind_type K_END      = 6'd36;
   localparam kind_type K_BADCHAR  = 6'd37;
   localparam kind_type K_UNTERM   = 6'd38;

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_OP,
      MODE_SLASH,
      MODE_COMMENT,
      MODE_NUMBER,
      MODE_IDENT,
      MODE_STRING
   } mode_type;

   typedef struct packed {
      kind_type kind;
      pos_type  start;
      pos_type  length;
      pos_type  line;
      logic     last;
   } token_type;

   typedef struct packed {
      logic [1:0]                  count;
      token_type [RESULTS_MAX-1:0] slot;
   } result_set_type;

   typedef struct packed {
      logic     valid;
      kind_type kind;
      pos_type  start;
      pos_type  length;
   } held_type;

   // keyword text, right aligned, in the order of the keyword kinds
   function automatic prefix_type kw_text(input logic [3:0] idx);
      prefix_type r;
      r = '0;
      unique case (idx)
         4'd0:  r[31:0] = "true";
         4'd1:  r[39:0] = "false";
         4'd2:  r[23:0] = "var";
         4'd3:  r[31:0] = "func";
         4'd4:  r[15:0] = "if";
         4'd5:  r[31:0] = "else";
         4'd6:  r[23:0] = "for";
         4'd7:  r[39:0] = "while";
         4'd8:  r[31:0] = "this";
         4'd9:  r[23:0] = "nil";
         4'd10: r[15:0] = "or";
         4'd11: r[23:0] = "and";
         4'd12: r[39:0] = "print";
         4'd13: r[47:0] = "return";
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic logic [3:0] kw_len(input logic [3:0] idx);
      logic [3:0] r;
      unique case (idx)
         4'd0, 4'd3, 4'd5, 4'd8: r = 4'd4;
         4'd1, 4'd7, 4'd12:      r = 4'd5;
         4'd2, 4'd6, 4'd9, 4'd11: r = 4'd3;
         4'd4, 4'd10:            r = 4'd2;
         4'd13:                  r = 4'd6;
         default:                r = 4'd15;
      endcase
      return r;
   endfunction

   function automatic pos_type sat_inc(input pos_type v);
      return (v == POS_MAX) ? v : v + 1'b1;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/sls_if.sv
// request and response channel interfaces of the token scanner
`default_nettype none

interface sls_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_byte;
   logic       is_final;

   modport source (output valid, output char_byte, output is_final, input ready);
   modport sink   (input valid, input char_byte, input is_final, output ready);
endinterface

interface sls_rsp_if;
   import sls_pkg::*;
   logic     valid;
   logic     ready;
   kind_type token_kind;
   pos_type  start_offset;
   pos_type  token_length;
   pos_type  line_no;
   logic     run_last;

   modport source (output valid, output token_kind, output start_offset,
                   output token_length, output line_no, output run_last, input ready);
   modport sink   (input valid, input token_kind, input start_offset,
                   input token_length, input line_no, input run_last, output ready);
endinterface

`default_nettype wire

FILE: hdl/sls_step.sv
// scanner state registers and per-byte token decision logic
`default_nettype none

module sls_step import sls_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           fire,
   input  logic [7:0]     char_byte,
   input  logic           is_final,
   output result_set_type result_set
);

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_BANG  = 8'h21;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_GT    = 8'h3E;

   mode_type   mode_ff, mode_in;
   logic [1:0] op_ff, op_in;
   pos_type    start_ff, start_in;
   pos_type    len_ff, len_in;
   pos_type    pos_ff, pos_in;
   pos_type    line_ff, line_in;
   prefix_type prefix_ff, prefix_in;
   logic       halted_ff, halted_in;

   logic       is_digit, is_alpha;
   logic       punct_v;
   kind_type   punct_kind;

   function automatic kind_type ident_kind(input pos_type l, input prefix_type p);
      kind_type k;
      k = K_IDENT;
      for (int i = KW_COUNT - 1; i >= 0; i--) begin
         if (l == POS_WIDTH'(kw_len(4'(i))) && p == kw_text(4'(i))) begin
            k = K_KEYWORD0 + kind_type'(i);
         end
      end
      return k;
   endfunction

   function automatic held_type held_token(input mode_type m, input logic [1:0] op,
                                           input pos_type s, input pos_type l,
                                           input prefix_type p);
      held_type h;
      h.valid  = 1'b1;
      h.kind   = K_NUMBER;
      h.start  = s;
      h.length = l;
      unique case (m)
         MODE_OP: begin
            h.kind   = K_OP_BASE + kind_type'({op, 1'b0});
            h.length = pos_type'(1);
         end
         MODE_SLASH: begin
            h.kind   = K_SLASH;
            h.length = pos_type'(1);
         end
         MODE_NUMBER: h.kind = K_NUMBER;
         MODE_IDENT:  h.kind = ident_kind(l, p);
         MODE_STRING: h.kind = K_UNTERM;
         default:     h.valid = 1'b0;
      endcase
      return h;
   endfunction

   assign is_digit = (char_byte >= 8'h30) && (char_byte <= 8'h39);
   assign is_alpha = ((char_byte >= 8'h61) && (char_byte <= 8'h7A)) ||
                     ((char_byte >= 8'h41) && (char_byte <= 8'h5A));

   always_comb begin
      punct_v    = 1'b1;
      punct_kind = '0;
      unique case (char_byte)
         8'h28:   punct_kind = 6'd0;
         8'h29:   punct_kind = 6'd1;
         8'h7B:   punct_kind = 6'd2;
         8'h7D:   punct_kind = 6'd3;
         8'h2C:   punct_kind = 6'd4;
         8'h2E:   punct_kind = 6'd5;
         8'h2D:   punct_kind = 6'd6;
         8'h2B:   punct_kind = 6'd7;
         8'h3B:   punct_kind = 6'd8;
         8'h2A:   punct_kind = 6'd9;
         default: punct_v = 1'b0;
      endcase
   end

   always_comb begin
      logic       again;
      held_type   hp;
      held_type   hf;
      logic [1:0] n;
      token_type  t [4];
      logic       tv [4];

      mode_in   = mode_ff;
      op_in     = op_ff;
      start_in  = start_ff;
      len_in    = len_ff;
      line_in   = line_ff;
      prefix_in = prefix_ff;
      halted_in = halted_ff;
      again     = 1'b1;
      for (int j = 0; j < 4; j++) begin
         t[j]  = '0;
         tv[j] = 1'b0;
      end

      hp = held_token(mode_ff, op_ff, start_ff, len_ff, prefix_ff);

      if (!halted_ff) begin
         // slot 0: what the held token makes of this byte
         unique case (mode_ff)
            MODE_OP: begin
               if (char_byte == CH_EQ) begin
                  tv[0]       = 1'b1;
                  t[0].kind   = K_OP_BASE + kind_type'({op_ff, 1'b1});
                  t[0].start  = start_ff;
                  t[0].length = pos_type'(2);
                  mode_in     = MODE_IDLE;
                  again       = 1'b0;
               end else begin
                  tv[0]       = hp.valid;
                  t[0].kind   = hp.kind;
                  t[0].start  = hp.start;
                  t[0].length = hp.length;
                  mode_in     = MODE_IDLE;
               end
            end
            MODE_SLASH: begin
               if (char_byte == CH_SLASH) begin
                  mode_in = MODE_COMMENT;
                  again   = 1'b0;
               end else begin
                  tv[0]       = hp.valid;
                  t[0].kind   = hp.kind;
                  t[0].start  = hp.start;
                  t[0].length = hp.length;
                  mode_in     = MODE_IDLE;
               end
            end
            MODE_COMMENT: begin
               if (char_byte == CH_NL || char_byte == CH_NUL) begin
                  mode_in = MODE_IDLE;
               end else begin
                  again = 1'b0;
               end
            end
            MODE_NUMBER, MODE_IDENT: begin
               if (is_digit || (mode_ff == MODE_NUMBER ? char_byte == CH_DOT : is_alpha)) begin
                  if (len_ff < pos_type'(KW_MAX_LEN)) begin
                     prefix_in = {prefix_ff[PREFIX_WIDTH-9:0], char_byte};
                  end
                  len_in = sat_inc(len_ff);
                  again  = 1'b0;
               end else begin
                  tv[0]       = hp.valid;
                  t[0].kind   = hp.kind;
                  t[0].start  = hp.start;
                  t[0].length = hp.length;
                  mode_in     = MODE_IDLE;
               end
            end
            MODE_STRING: begin
               if (char_byte == CH_QUOTE) begin
                  tv[0]       = 1'b1;
                  t[0].kind   = K_STRING;
                  t[0].start  = start_ff;
                  t[0].length = len_ff;
                  mode_in     = MODE_IDLE;
               end else begin
                  len_in = sat_inc(len_ff);
                  if (char_byte == CH_NL) begin
                     line_in = sat_inc(line_ff);
                  end
               end
               again = 1'b0;
            end
            default: mode_in = MODE_IDLE;
         endcase

         // slot 1: the byte seen from idle
         if (again) begin
            if (punct_v) begin
               tv[1]       = 1'b1;
               t[1].kind   = punct_kind;
               t[1].start  = pos_ff;
               t[1].length = pos_type'(1);
            end else if (char_byte == CH_BANG || char_byte == CH_EQ ||
                         char_byte == CH_LT || char_byte == CH_GT) begin
               op_in     = (char_byte == CH_BANG) ? 2'd0 :
                           (char_byte == CH_EQ)   ? 2'd1 :
                           (char_byte == CH_LT)   ? 2'd2 : 2'd3;
               mode_in   = MODE_OP;
               start_in  = pos_ff;
               len_in    = '0;
               prefix_in = '0;
            end else if (char_byte == CH_SLASH) begin
               mode_in   = MODE_SLASH;
               start_in  = pos_ff;
               len_in    = '0;
               prefix_in = '0;
            end else if (char_byte == CH_SP || char_byte == CH_CR || char_byte == CH_TAB) begin
               mode_in = MODE_IDLE;
            end else if (char_byte == CH_NL) begin
               line_in = sat_inc(line_ff);
            end else if (char_byte == CH_NUL) begin
               tv[1]       = 1'b1;
               t[1].kind   = K_END;
               t[1].start  = pos_ff;
               t[1].length = '0;
            end else if (char_byte == CH_QUOTE) begin
               mode_in   = MODE_STRING;
               start_in  = sat_inc(pos_ff);
               len_in    = '0;
               prefix_in = '0;
            end else if (is_digit || is_alpha) begin
               mode_in   = is_digit ? MODE_NUMBER : MODE_IDENT;
               start_in  = pos_ff;
               len_in    = pos_type'(1);
               prefix_in = prefix_type'(char_byte);
            end else begin
               tv[1]       = 1'b1;
               t[1].kind   = K_BADCHAR;
               t[1].start  = pos_ff;
               t[1].length = pos_type'(1);
               halted_in   = 1'b1;
               mode_in     = MODE_IDLE;
            end
         end
      end

      t[0].line = line_ff;
      t[1].line = line_ff;
      pos_in    = sat_inc(pos_ff);

      // slots 2 and 3: flush and END at the last byte of a source
      hf = held_token(mode_in, op_in, start_in, len_in, prefix_in);
      if (is_final) begin
         tv[2]       = hf.valid && !halted_in;
         t[2].kind   = hf.kind;
         t[2].start  = hf.start;
         t[2].length = hf.length;
         t[2].line   = line_in;
         tv[3]       = 1'b1;
         t[3].kind   = K_END;
         t[3].start  = pos_in;
         t[3].length = '0;
         t[3].line   = line_in;
         mode_in     = MODE_IDLE;
         op_in       = '0;
         start_in    = '0;
         len_in      = '0;
         pos_in      = '0;
         line_in     = pos_type'(1);
         prefix_in   = '0;
         halted_in   = 1'b0;
      end

      // pack the live slots in order, mark the last one
      result_set = '0;
      n = '0;
      for (int j = 0; j < 4; j++) begin
         if (tv[j] && n != 2'd3) begin
            result_set.slot[n] = t[j];
            n = n + 1'b1;
         end
      end
      if (n != 2'd0) begin
         result_set.slot[n - 1'b1].last = 1'b1;
      end
      result_set.count = n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         op_ff     <= '0;
         start_ff  <= '0;
         len_ff    <= '0;
         pos_ff    <= '0;
         line_ff   <= pos_type'(1);
         prefix_ff <= '0;
         halted_ff <= 1'b0;
      end else if (fire) begin
         mode_ff   <= mode_in;
         op_ff     <= op_in;
         start_ff  <= start_in;
         len_ff    <= len_in;
         pos_ff    <= pos_in;
         line_ff   <= line_in;
         prefix_ff <= prefix_in;
         halted_ff <= halted_in;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/sls_outq.sv
// three-deep result register that hands tokens out one per cycle while the response side is ready
`default_nettype none

module sls_outq import sls_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           load,
   input  result_set_type set_in,
   input  logic           pop,
   output token_type      head,
   output logic [1:0]     count
);

   token_type [RESULTS_MAX-1:0] slot_ff, slot_in;
   logic [1:0]                  count_ff, count_in;

   always_comb begin
      slot_in  = slot_ff;
      count_in = count_ff;
      if (load) begin
         slot_in  = set_in.slot;
         count_in = set_in.count;
      end else if (pop && count_ff != 2'd0) begin
         for (int i = 0; i < RESULTS_MAX - 1; i++) begin
            slot_in[i] = slot_ff[i + 1];
         end
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign head  = slot_ff[0];
   assign count = count_ff;

endmodule

`default_nettype wire

FILE: hdl/script_lexer_token_scanner_core.sv
// top level of the streaming token scanner
// order: the first token of a request shows on the response side in the cycle after acceptance
// throughput: one request per cycle while each gives at most one token and the response side
//   is ready; a request that gives more tokens holds off the next one until the three-deep result
//   register is down to one token that is being taken; it drains one token per cycle while ready
// reset: synchronous, scanner back to idle at line 1 and offset 0, result register empty
`default_nettype none

module script_lexer_token_scanner_core import sls_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   sls_req_if.sink          req_chan,
   sls_rsp_if.source        rsp_chan
);

   logic           req_fire;
   logic           rsp_fire;
   result_set_type result_set;
   token_type      head;
   logic [1:0]     count;

   // a request moves when both sides of the handshake agree
   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_fire = rsp_chan.valid && rsp_chan.ready;

   // take a new request whenever the result register will be empty after this cycle,
   // so a lone waiting token does not stall the byte stream
   assign req_chan.ready = (count == 2'd0) || (count == 2'd1 && rsp_chan.ready);

   // byte classification, held-token state and per-byte token selection
   sls_step u_step (
      .clock      (clock),
      .reset      (reset),
      .fire       (req_fire),
      .char_byte  (req_chan.char_byte),
      .is_final   (req_chan.is_final),
      .result_set (result_set)
   );

   // up to three tokens per byte, held until the response side takes them
   sls_outq u_outq (
      .clock  (clock),
      .reset  (reset),
      .load   (req_fire),
      .set_in (result_set),
      .pop    (rsp_fire),
      .head   (head),
      .count  (count)
   );

   // response side shows the oldest waiting token
   assign rsp_chan.valid        = (count != 2'd0);
   assign rsp_chan.token_kind   = head.kind;
   assign rsp_chan.start_offset = head.start;
   assign rsp_chan.token_length = head.length;
   assign rsp_chan.line_no      = head.line;
   assign rsp_chan.run_last     = head.last;

endmodule

`default_nettype wire

FILE: hdl/sls_checker.sv
// port-level assertions of the token scanner and their bind
`default_nettype none
`include "assert_macros.svh"

module sls_checker import sls_pkg::*; (
   input logic     clock,
   input logic     reset,
   input logic     req_valid,
   input logic     req_ready,
   input logic     req_is_final,
   input logic     rsp_valid,
   input logic     rsp_ready,
   input kind_type rsp_token_kind,
   input pos_type  rsp_start_offset,
   input pos_type  rsp_token_length,
   input pos_type  rsp_line_no,
   input logic     rsp_run_last
);

   `SLS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_token_kind) && $stable(rsp_start_offset) && $stable(rsp_token_length) && $stable(rsp_line_no) && $stable(rsp_run_last), "stalled token changed")
   `SLS_ASSERT_NEXT(a_final_gives_token, clock, reset, req_valid && req_ready && req_is_final, rsp_valid, "last byte gave no token")
   `SLS_ASSERT_SAME(a_end_empty, clock, reset, rsp_valid && rsp_token_kind == K_END, rsp_token_length == '0, "end token with length")
   `SLS_ASSERT_SAME(a_line_nonzero, clock, reset, rsp_valid, rsp_line_no != '0 && rsp_token_kind <= K_UNTERM, "bad line or kind")

endmodule

bind script_lexer_token_scanner_core sls_checker u_sls_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .req_is_final     (req_chan.is_final),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_token_kind   (rsp_chan.token_kind),
   .rsp_start_offset (rsp_chan.start_offset),
   .rsp_token_length (rsp_chan.token_length),
   .rsp_line_no      (rsp_chan.line_no),
   .rsp_run_last     (rsp_chan.run_last)
);

`default_nettype wire

FILE: tb/script_lexer_token_scanner_core_tb.sv
// self-checking testbench of the token scanner core, with token predictor and scoreboard
`timescale 1ns / 100ps

module script_lexer_token_scanner_core_tb;
   import sls_pkg::*;

   localparam int CLOCK_PERIOD = 12;
   localparam int RESET_CYCLES = 8;
   localparam int MAX_GAP      = 8;
   // the first token shows in the cycle after acceptance, then the result register may still hold two more
   localparam int DRAIN_SLACK  = 6;
   localparam int RANDOM_ITEMS = 70;
   localparam int LONG_STALL   = 60;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int REPORT_LIMIT = 10;

   localparam logic [7:0] CH_NUL     = 8'h00;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_LF      = 8'h0a;
   localparam logic [7:0] CH_CR      = 8'h0d;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_QUOTE   = 8'h22;
   localparam logic [7:0] CH_DOT     = 8'h2e;
   localparam logic [7:0] CH_SLASH   = 8'h2f;
   localparam logic [7:0] CH_BANG    = 8'h21;
   localparam logic [7:0] CH_EQUALS  = 8'h3d;
   localparam logic [7:0] CH_LESS    = 8'h3c;
   localparam logic [7:0] CH_GREATER = 8'h3e;
   localparam logic [7:0] CH_TOP_BIT = 8'h80;
   localparam logic [7:0] CH_ALL_SET = 8'hff;

   localparam pos_type NO_BYTES  = pos_type'(0);
   localparam pos_type ONE_BYTE  = pos_type'(1);
   localparam pos_type TWO_BYTES = pos_type'(2);

   // token kinds in the order the block numbers them
   typedef enum logic [5:0] {
      TK_LPAREN, TK_RPAREN, TK_LBRACE, TK_RBRACE, TK_COMMA, TK_DOT, TK_MINUS, TK_PLUS,
      TK_SEMI, TK_STAR, TK_BANG, TK_BANG_EQ, TK_EQ, TK_EQ_EQ, TK_LESS, TK_LESS_EQ,
      TK_GREATER, TK_GREATER_EQ, TK_SLASH, TK_STRING, TK_NUMBER, TK_IDENT,
      TK_TRUE, TK_FALSE, TK_VAR, TK_FUNC, TK_IF, TK_ELSE, TK_FOR, TK_WHILE, TK_THIS,
      TK_NIL, TK_OR, TK_AND, TK_PRINT, TK_RETURN, TK_END, TK_BADCHAR, TK_UNTERM
   } token_code_e;

   // shapes of source text that the random sources are built from
   typedef enum int {
      LX_PUNCT, LX_OP, LX_KEYWORD, LX_NEAR_KEYWORD, LX_IDENT, LX_NUMBER, LX_STRING,
      LX_COMMENT, LX_SLASH, LX_BLANK, LX_ZERO, LX_NOISE
   } lexeme_e;

   logic clock;
   logic reset;

   sls_req_if req_bus ();
   sls_rsp_if rsp_bus ();

   script_lexer_token_scanner_core uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // mirror of the scanner state
   mode_type    scan_state;
   token_code_e held_op;
   pos_type     tok_start;
   pos_type     tok_len;
   pos_type     next_offset;
   pos_type     line_now;
   prefix_type  kw_prefix;
   logic        scan_halted;

   token_type   expected_tokens [$];
   int          emitted_now;

   // stimulus control shared with the response side
   bit          sender_idles;
   bit          receiver_idles;
   int          stall_request;
   int          live_items;
   int          mismatch_count;
   int          cycle_count;

   logic [7:0]  source_bytes [$];
   string       punct_set = "(){},.-+;*";
   string       op_set    = "!=<>";
   string       keywords [KW_COUNT] = '{"true", "false", "var", "func", "if", "else", "for",
                                        "while", "this", "nil", "or", "and", "print",
                                        "return"};

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   function automatic pos_type step_sat(input pos_type v);
      return v + pos_type'(v != POS_MAX);
   endfunction

   function automatic logic is_numeral(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_letter(input logic [7:0] c);
      return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
   endfunction

   // back to the state after reset: idle, line 1, offset 0
   function automatic void clear_scanner();
      scan_state  = MODE_IDLE;
      held_op     = TK_BANG;
      tok_start   = '0;
      tok_len     = '0;
      next_offset = '0;
      line_now    = ONE_BYTE;
      kw_prefix   = '0;
      scan_halted = 1'b0;
   endfunction

   function automatic void push_token(input token_code_e code, input pos_type start,
                                      input pos_type len);
      token_type t;
      t.kind   = code;
      t.start  = start;
      t.length = len;
      t.line   = line_now;
      t.last   = 1'b0;
      expected_tokens.insert(expected_tokens.size(), t);
      emitted_now++;
   endfunction

   // only the first few characters are kept for the keyword compare
   function automatic void grow_token(input logic [7:0] c);
      if (tok_len < pos_type'(KW_MAX_LEN))
         kw_prefix = {kw_prefix[PREFIX_WIDTH-9:0], c};
      tok_len = step_sat(tok_len);
   endfunction

   function automatic void open_token(input mode_type m, input pos_type start);
      scan_state = m;
      tok_start  = start;
      tok_len    = '0;
      kw_prefix  = '0;
   endfunction

   // alphanumerics are never zero, so the packed prefix also fixes the length
   function automatic token_code_e word_code();
      token_code_e r;
      r = TK_IDENT;
      if (tok_len <= pos_type'(KW_MAX_LEN)) begin
         case (kw_prefix)
            prefix_type'("true"):   r = TK_TRUE;
            prefix_type'("false"):  r = TK_FALSE;
            prefix_type'("var"):    r = TK_VAR;
            prefix_type'("func"):   r = TK_FUNC;
            prefix_type'("if"):     r = TK_IF;
            prefix_type'("else"):   r = TK_ELSE;
            prefix_type'("for"):    r = TK_FOR;
            prefix_type'("while"):  r = TK_WHILE;
            prefix_type'("this"):   r = TK_THIS;
            prefix_type'("nil"):    r = TK_NIL;
            prefix_type'("or"):     r = TK_OR;
            prefix_type'("and"):    r = TK_AND;
            prefix_type'("print"):  r = TK_PRINT;
            prefix_type'("return"): r = TK_RETURN;
            default:                r = TK_IDENT;
         endcase
      end
      return r;
   endfunction

   function automatic void flush_pending();
      case (scan_state)
         MODE_OP:     push_token(held_op, tok_start, ONE_BYTE);
         MODE_SLASH:  push_token(TK_SLASH, tok_start, ONE_BYTE);
         MODE_NUMBER: push_token(TK_NUMBER, tok_start, tok_len);
         MODE_IDENT:  push_token(word_code(), tok_start, tok_len);
         MODE_STRING: push_token(TK_UNTERM, tok_start, tok_len);
         default: ;
      endcase
      scan_state = MODE_IDLE;
   endfunction

   // a byte seen with nothing held
   function automatic void scan_fresh(input logic [7:0] c, input pos_type pos);
      case (c)
         "(": push_token(TK_LPAREN, pos, ONE_BYTE);
         ")": push_token(TK_RPAREN, pos, ONE_BYTE);
         "{": push_token(TK_LBRACE, pos, ONE_BYTE);
         "}": push_token(TK_RBRACE, pos, ONE_BYTE);
         ",": push_token(TK_COMMA, pos, ONE_BYTE);
         ".": push_token(TK_DOT, pos, ONE_BYTE);
         "-": push_token(TK_MINUS, pos, ONE_BYTE);
         "+": push_token(TK_PLUS, pos, ONE_BYTE);
         ";": push_token(TK_SEMI, pos, ONE_BYTE);
         "*": push_token(TK_STAR, pos, ONE_BYTE);
         CH_BANG: begin
            held_op = TK_BANG;
            open_token(MODE_OP, pos);
         end
         CH_EQUALS: begin
            held_op = TK_EQ;
            open_token(MODE_OP, pos);
         end
         CH_LESS: begin
            held_op = TK_LESS;
            open_token(MODE_OP, pos);
         end
         CH_GREATER: begin
            held_op = TK_GREATER;
            open_token(MODE_OP, pos);
         end
         CH_SLASH: open_token(MODE_SLASH, pos);
         CH_SPACE, CH_CR, CH_TAB: ;
         CH_LF:    line_now = step_sat(line_now);
         CH_NUL:   push_token(TK_END, pos, NO_BYTES);
         // string content starts after the quote
         CH_QUOTE: open_token(MODE_STRING, step_sat(pos));
         default: begin
            if (is_numeral(c)) begin
               open_token(MODE_NUMBER, pos);
               grow_token(c);
            end else if (is_letter(c)) begin
               open_token(MODE_IDENT, pos);
               grow_token(c);
            end else begin
               push_token(TK_BADCHAR, pos, ONE_BYTE);
               scan_halted = 1'b1;
               scan_state  = MODE_IDLE;
            end
         end
      endcase
   endfunction

   // expected tokens of one accepted request, appended in order
   function automatic void predict_tokens(input logic [7:0] c, input logic fin);
      pos_type   pos;
      logic      rescan;
      token_type tail;
      pos         = next_offset;
      emitted_now = 0;
      if (!scan_halted) begin
         rescan = 1'b1;
         case (scan_state)
            MODE_OP: begin
               // '=' always joins, whatever comes after it
               if (c == CH_EQUALS) begin
                  push_token(token_code_e'(held_op + 1), tok_start, TWO_BYTES);
                  scan_state = MODE_IDLE;
                  rescan     = 1'b0;
               end else
                  flush_pending();
            end
            MODE_SLASH: begin
               if (c == CH_SLASH) begin
                  scan_state = MODE_COMMENT;
                  rescan     = 1'b0;
               end else
                  flush_pending();
            end
            MODE_COMMENT: begin
               // the newline or zero that ends a comment is scanned again
               if ((c == CH_LF) || (c == CH_NUL))
                  scan_state = MODE_IDLE;
               else
                  rescan = 1'b0;
            end
            MODE_NUMBER: begin
               if (is_numeral(c) || (c == CH_DOT)) begin
                  grow_token(c);
                  rescan = 1'b0;
               end else
                  flush_pending();
            end
            MODE_IDENT: begin
               if (is_numeral(c) || is_letter(c)) begin
                  grow_token(c);
                  rescan = 1'b0;
               end else
                  flush_pending();
            end
            MODE_STRING: begin
               if (c == CH_QUOTE) begin
                  push_token(TK_STRING, tok_start, tok_len);
                  scan_state = MODE_IDLE;
               end else begin
                  tok_len = step_sat(tok_len);
                  if (c == CH_LF)
                     line_now = step_sat(line_now);
               end
               rescan = 1'b0;
            end
            default: scan_state = MODE_IDLE;
         endcase
         if (rescan)
            scan_fresh(c, pos);
      end
      next_offset = step_sat(next_offset);
      // last byte of a source: flush, end marker, then a fresh scanner
      if (fin) begin
         if (!scan_halted)
            flush_pending();
         push_token(TK_END, next_offset, NO_BYTES);
         clear_scanner();
      end
      if (emitted_now > 0) begin
         tail      = expected_tokens.pop_back();
         tail.last = 1'b1;
         expected_tokens.insert(expected_tokens.size(), tail);
      end
   endfunction

   // ---------------------------------------------------------------- request side

   // one byte per request, held until the block takes it
   task automatic send_byte(input logic [7:0] c, input logic fin);
      int gap;
      gap = sender_idles ? $urandom_range(0, MAX_GAP) : 0;
      repeat (gap) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.char_byte <= c;
      req_bus.is_final  <= fin;
      do begin
         @(posedge clock);
      end while (!req_bus.ready);
      // bytes swallowed while halted do not count as live traffic
      if (!scan_halted)
         live_items++;
      predict_tokens(c, fin);
   endtask

   task automatic send_text(input string s, input logic fin);
      for (int i = 0; i < s.len(); i++)
         send_byte(s[i], fin && (i == s.len() - 1));
   endtask

   // sender pauses until every expected token is out, plus the tail of the pipe
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (expected_tokens.size() != 0)
         @(posedge clock);
      repeat (DRAIN_SLACK) @(posedge clock);
   endtask

   // ---------------------------------------------------------------- random sources

   function automatic logic [7:0] random_alnum();
      int r;
      r = $urandom_range(0, 61);
      if (r < 26)
         return 8'("a" + r);
      else if (r < 52)
         return 8'("A" + r - 26);
      return 8'("0" + r - 52);
   endfunction

   function automatic void append_byte(input logic [7:0] b);
      source_bytes.insert(source_bytes.size(), b);
   endfunction

   function automatic void add_text(input string s);
      for (int i = 0; i < s.len(); i++)
         append_byte(s[i]);
   endfunction

   function automatic void add_lexeme(input bit noisy);
      lexeme_e    shape;
      string      word;
      int         n;
      logic [7:0] b;
      shape = lexeme_e'($urandom_range(0, noisy ? LX_NOISE : LX_ZERO));
      case (shape)
         LX_PUNCT: append_byte(punct_set[$urandom_range(0, 9)]);
         LX_OP: begin
            append_byte(op_set[$urandom_range(0, 3)]);
            if ($urandom_range(0, 1))
               append_byte(CH_EQUALS);
         end
         LX_KEYWORD: add_text(keywords[$urandom_range(0, KW_COUNT - 1)]);
         LX_NEAR_KEYWORD: begin
            // one character short or one too long
            word = keywords[$urandom_range(0, KW_COUNT - 1)];
            if ($urandom_range(0, 1))
               add_text(word.substr(0, word.len() - 2));
            else begin
               add_text(word);
               append_byte(random_alnum());
            end
         end
         LX_IDENT: begin
            append_byte(8'("a" + $urandom_range(0, 25)));
            n = ($urandom_range(0, 7) == 0) ? 10 : $urandom_range(0, 7);
            repeat (n) append_byte(random_alnum());
         end
         LX_NUMBER: begin
            append_byte(8'("0" + $urandom_range(0, 9)));
            repeat ($urandom_range(0, 5))
               append_byte(($urandom_range(0, 4) == 0) ? CH_DOT
                                                       : 8'("0" + $urandom_range(0, 9)));
         end
         LX_STRING: begin
            append_byte(CH_QUOTE);
            repeat ($urandom_range(0, 6)) begin
               n = $urandom_range(0, 9);
               if (n == 0)
                  b = CH_LF;
               else if (n == 1)
                  b = CH_NUL;
               else begin
                  b = 8'($urandom_range(32, 126));
                  if (b == CH_QUOTE)
                     b = "q";
               end
               append_byte(b);
            end
            append_byte(CH_QUOTE);
         end
         LX_COMMENT: begin
            // any byte but newline and zero stays inside the comment
            append_byte(CH_SLASH);
            append_byte(CH_SLASH);
            repeat ($urandom_range(0, 5)) begin
               b = 8'($urandom_range(1, 255));
               append_byte((b == CH_LF) ? 8'("x") : b);
            end
            append_byte($urandom_range(0, 3) == 0 ? CH_NUL : CH_LF);
         end
         LX_SLASH: append_byte(CH_SLASH);
         LX_BLANK: begin
            n = $urandom_range(0, 3);
            append_byte((n == 0) ? CH_SPACE : (n == 1) ? CH_TAB :
                        (n == 2) ? CH_CR : CH_LF);
         end
         LX_ZERO: append_byte(CH_NUL);
         default: append_byte(8'($urandom_range(0, 255)));
      endcase
   endfunction

   // one source of well-formed lexemes, some with noise or an open string at the end
   task automatic send_random_source();
      int lexemes;
      bit noisy;
      source_bytes.delete();
      lexemes = $urandom_range(1, 10);
      noisy   = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < lexemes; k++) begin
         add_lexeme(noisy);
         if ($urandom_range(0, 1))
            append_byte(CH_SPACE);
      end
      if ($urandom_range(0, 5) == 0) begin
         append_byte(CH_QUOTE);
         append_byte(random_alnum());
      end
      foreach (source_bytes[i])
         send_byte(source_bytes[i], i == source_bytes.size() - 1);
   endtask

   // ---------------------------------------------------------------- response side

   // receiver: random hold-off before each token, long stall on request
   initial begin : token_drain
      int gap;
      int hold;
      rsp_bus.ready <= 1'b0;
      do begin
         @(posedge clock);
      end while (reset);
      forever begin
         if (stall_request > 0) begin
            hold          = stall_request;
            stall_request = 0;
            repeat (hold) begin
               rsp_bus.ready <= 1'b0;
               @(posedge clock);
            end
         end
         gap = receiver_idles ? $urandom_range(0, MAX_GAP) : 0;
         repeat (gap) begin
            rsp_bus.ready <= 1'b0;
            @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do begin
            @(posedge clock);
         end while (!rsp_bus.valid);
      end
   end

   task automatic flag_token(input string why, input token_type want);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         $display("%0t: token %s: expected kind %0d start %0d len %0d line %0d last %0b",
                  $realtime, why, want.kind, want.start, want.length, want.line, want.last);
         $display("%0t: token %s: actual kind %0d start %0d len %0d line %0d last %0b",
                  $realtime, why, rsp_bus.token_kind, rsp_bus.start_offset,
                  rsp_bus.token_length, rsp_bus.line_no, rsp_bus.run_last);
      end
   endtask

   // every accepted token against the oldest expectation
   always @(posedge clock) begin : token_check
      token_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_tokens.size() == 0) begin
            want = '0;
            flag_token("not expected", want);
         end else begin
            want = expected_tokens.pop_front();
            if ((rsp_bus.token_kind != want.kind) || (rsp_bus.start_offset != want.start) ||
                (rsp_bus.token_length != want.length) || (rsp_bus.line_no != want.line) ||
                (rsp_bus.run_last != want.last))
               flag_token("mismatch", want);
         end
      end
   end

   // ---------------------------------------------------------------- tests

   // every punctuation mark and every operator but a lone '='; '>=' followed by a digit must still join
   task automatic test_punctuation_and_operators();
      send_text("(){},.-+;*!!===<<=>>=9", 1'b1);
      wait_drained();
   endtask

   // lone slash, comment ended by newline, comment ended by zero, slash flushed by the last byte
   task automatic test_slash_and_comments();
      send_text("a/b//c d\n//x", 1'b0);
      send_byte(CH_NUL, 1'b0);
      send_byte(CH_SLASH, 1'b1);
      wait_drained();
   endtask

   // newline and zero inside strings, whitespace, open string at the last byte
   task automatic test_strings();
      send_text("\"a\nb\"", 1'b0);
      send_byte(CH_QUOTE, 1'b0);
      send_byte(CH_NUL, 1'b0);
      send_byte(CH_QUOTE, 1'b0);
      send_text(" \t", 1'b0);
      send_byte(CH_CR, 1'b0);
      send_text("\"op", 1'b1);
      wait_drained();
   endtask

   // zero mid-source, bad character halts, halted bytes ignored, bad byte as the last one
   task automatic test_zero_and_bad_char();
      send_byte(CH_NUL, 1'b0);
      send_text("x@", 1'b0);
      send_byte(CH_ALL_SET, 1'b0);
      send_text("(", 1'b0);
      send_byte(CH_TOP_BIT, 1'b1);
      send_byte(CH_ALL_SET, 1'b1);
      wait_drained();
   endtask

   // keyword boundaries: exact, one too long, wrong case
   task automatic test_keyword_edges();
      send_text("return returns iF nil", 1'b1);
      wait_drained();
   endtask

   // receiver holds off while the sender keeps offering, so the input stalls
   task automatic test_backpressure();
      sender_idles   = 1'b0;
      receiver_idles = 1'b0;
      stall_request  = LONG_STALL;
      send_text("(,.;{}()+-*;;(()),,..", 1'b0);
      // held operator, punctuation and end marker from one request
      send_text("<;", 1'b1);
      wait_drained();
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
   endtask

   // random sources, with stretches of idling and stretches without
   task automatic test_random_sources();
      live_items = 0;
      while (live_items < RANDOM_ITEMS) begin
         sender_idles   = ($urandom_range(0, 3) != 0);
         receiver_idles = ($urandom_range(0, 3) != 0);
         send_random_source();
      end
      wait_drained();
   endtask

   // ---------------------------------------------------------------- run control

   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("script_lexer_token_scanner_core_tb: FAIL");
      $finish;
   end

   initial begin : stimulus
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.char_byte <= CH_NUL;
      req_bus.is_final  <= 1'b0;
      sender_idles      = 1'b1;
      receiver_idles    = 1'b1;
      stall_request     = 0;
      live_items        = 0;
      mismatch_count    = 0;
      clear_scanner();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_punctuation_and_operators();
      test_slash_and_comments();
      test_strings();
      test_zero_and_bad_char();
      test_keyword_edges();
      test_backpressure();
      test_random_sources();

      if ((mismatch_count == 0) && (expected_tokens.size() == 0))
         $display("script_lexer_token_scanner_core_tb: PASS");
      else
         $display("script_lexer_token_scanner_core_tb: FAIL");
      $finish;
   end

endmodule
